>>> rtl/mipsx_pkg.sv
// ---------------------------------------------------------------------------
// mipsx_pkg
// shared constants, types and helpers for the mips subset executor
// ---------------------------------------------------------------------------
package mipsx_pkg;

  // default data memory size in bytes (a power of two, at least 4)
  localparam int unsigned DATA_MEM_BYTES_DEF = 65536;

  localparam logic [31:0] HALT_WORD        = 32'hFFFF_FFFF;
  localparam logic [31:0] JUMP_REGION_MASK = 32'hF000_0000;

  // primary opcodes
  localparam logic [5:0] OP_RTYPE = 6'h00;
  localparam logic [5:0] OP_J     = 6'h02;
  localparam logic [5:0] OP_BEQ   = 6'h04;
  localparam logic [5:0] OP_ADDIU = 6'h09;
  localparam logic [5:0] OP_LW    = 6'h23;
  localparam logic [5:0] OP_SW    = 6'h2B;

  // r-type selection by the low three funct bits
  localparam logic [2:0] FN_ADDU = 3'd1;
  localparam logic [2:0] FN_SUBU = 3'd3;
  localparam logic [2:0] FN_AND  = 3'd4;
  localparam logic [2:0] FN_OR   = 3'd5;
  localparam logic [2:0] FN_NOR  = 3'd7;

  // register file write port
  typedef struct packed {
    logic        en;
    logic [4:0]  idx;
    logic [31:0] data;
  } rf_wr_t;

  // data memory access, addr is the raw effective address
  typedef struct packed {
    logic        wr;
    logic        rd;
    logic [31:0] addr;
    logic [31:0] wdata;
  } dm_req_t;

  function automatic logic [31:0] sign_ext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

endpackage

>>> rtl/mipsx_if.sv
// ---------------------------------------------------------------------------
// mipsx_if
// valid/ready channels: instruction requests in, execution results out
// ---------------------------------------------------------------------------
interface mipsx_instr_if;
  logic        valid;
  logic        ready;
  logic [31:0] instruction_word;

  modport source (output valid, output instruction_word, input ready);
  modport sink   (input valid, input instruction_word, output ready);
endinterface

interface mipsx_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] next_pc;
  logic        halted;
  logic        reg_write_done;
  logic [4:0]  reg_write_index;
  logic [31:0] reg_write_value;
  logic        mem_write_done;
  logic [15:0] mem_write_address;
  logic [31:0] mem_write_value;

  modport source (
    output valid, output next_pc, output halted, output reg_write_done,
    output reg_write_index, output reg_write_value, output mem_write_done,
    output mem_write_address, output mem_write_value, input ready
  );
  modport sink (
    input valid, input next_pc, input halted, input reg_write_done,
    input reg_write_index, input reg_write_value, input mem_write_done,
    input mem_write_address, input mem_write_value, output ready
  );
endinterface

>>> rtl/mipsx_regfile.sv
// ---------------------------------------------------------------------------
// mipsx_regfile
// 32 x 32 register file, two registered read ports, one write port
// ---------------------------------------------------------------------------
module mipsx_regfile (
  input  logic                clk,
  input  logic                rst,
  input  logic                rd_en,
  input  logic [4:0]          rs_idx,
  input  logic [4:0]          rt_idx,
  input  mipsx_pkg::rf_wr_t   wr,
  output logic [31:0]         rs_data,
  output logic [31:0]         rt_data
);
  import mipsx_pkg::*;

  logic [31:0] regs [32];
  logic [31:0] vld;

  // valid bits make unwritten entries read as zero after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr.en) begin
      vld[wr.idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      regs[wr.idx] <= wr.data;
    end
  end

  // write-through when a read hits the entry written at the same edge
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr.en && wr.idx == rs_idx) begin
        rs_data <= wr.data;
      end else begin
        rs_data <= vld[rs_idx] ? regs[rs_idx] : '0;
      end
      if (wr.en && wr.idx == rt_idx) begin
        rt_data <= wr.data;
      end else begin
        rt_data <= vld[rt_idx] ? regs[rt_idx] : '0;
      end
    end
  end

endmodule

>>> rtl/mipsx_dmem.sv
// ---------------------------------------------------------------------------
// mipsx_dmem
// byte addressed big-endian data memory in four byte lanes, cleared after reset
// ---------------------------------------------------------------------------
module mipsx_dmem #(
  parameter int unsigned DATA_MEM_BYTES = mipsx_pkg::DATA_MEM_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  mipsx_pkg::dm_req_t req,
  output logic               busy,
  output logic [31:0]        rdata
);
  import mipsx_pkg::*;

  localparam int unsigned ROWS  = DATA_MEM_BYTES / 4;
  localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [31:0] BYTE_MASK = 32'(DATA_MEM_BYTES - 1);
  localparam logic [29:0] ROW_MASK  = 30'(ROWS - 1);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

  logic [31:0]      base;
  logic [1:0]       shift;
  logic [1:0]       shift_q;
  logic [ROW_W-1:0] clr_row;
  logic [7:0]       lane_q [4];

  assign base  = req.addr & BYTE_MASK;
  assign shift = base[1:0];

  // clearing sweep, one row of all four lanes per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_row <= '0;
    end else if (busy) begin
      clr_row <= clr_row + 1'b1;
      if (clr_row == LAST_ROW) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd) begin
      shift_q <= shift;
    end
  end

  for (genvar j = 0; j < 4; j++) begin : g_lane
    logic [7:0]       mem [ROWS];
    logic [ROW_W-1:0] row;
    logic [1:0]       kk;
    logic [7:0]       wbyte;

    // lanes below the start byte wrap into the following row
    assign row   = ROW_W'((base[31:2] + 30'(2'(j) < shift)) & ROW_MASK);
    assign kk    = 2'(j) - shift;
    assign wbyte = 8'(req.wdata >> {~kk, 3'b000});

    always_ff @(posedge clk) begin
      if (busy) begin
        mem[clr_row] <= '0;
      end else if (req.wr) begin
        mem[row] <= wbyte;
      end
      if (req.rd) begin
        lane_q[j] <= mem[row];
      end
    end
  end

  // byte at the lowest address goes to the top of the word
  always_comb begin
    rdata = '0;
    for (int k = 0; k < 4; k++) begin
      rdata[31 - 8*k -: 8] = lane_q[2'(shift_q + 2'(k))];
    end
  end

endmodule

>>> rtl/mips_subset_instruction_executor_core.sv
// ---------------------------------------------------------------------------
// mips_subset_instruction_executor_core
// executes one instruction word per request: addu subu and or nor, addiu,
// beq, lw, sw, j and the halt word, reporting next pc and writes
// ---------------------------------------------------------------------------
//
//   channel  direction  payload
//   -------  ---------  ----------------------------------------------------
//   instr    in         instruction_word
//   result   out        next_pc, halted, reg/mem write done, index, address,
//                       value
//
// register file read at the accepting edge, execute and data memory access
// in the next cycle, write-back after that while the following instruction
// is already reading its operands; none is taken while one is in execute
// load data comes from the synchronous data memory read
// after reset the data memory is cleared row by row, DATA_MEM_BYTES/4 rows
// (16384 at the default size); instr.ready stays low during that sweep
// a result that is not taken holds write-back and stops accepting requests
// unchecked by the core: DATA_MEM_BYTES must be a power of two
// ---------------------------------------------------------------------------
module mips_subset_instruction_executor_core #(
  parameter int unsigned DATA_MEM_BYTES = mipsx_pkg::DATA_MEM_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  mipsx_instr_if.sink    instr,
  mipsx_result_if.source result
);
  import mipsx_pkg::*;

  localparam logic [31:0] BYTE_MASK = 32'(DATA_MEM_BYTES - 1);

  // architectural state kept in flops
  logic [31:0] pc;
  logic        halt_seen;

  // execute stage
  logic        ex_valid;
  logic [31:0] ex_instr;

  // write-back stage
  logic        wb_valid;
  logic [31:0] wb_next_pc;
  logic        wb_halted;
  logic        wb_rw;
  logic [4:0]  wb_ri;
  logic [31:0] wb_rv;
  logic        wb_load;
  logic        wb_mw;
  logic [15:0] wb_ma;
  logic [31:0] wb_mv;
  logic        wb_fire;

  logic        accept;
  logic        dm_busy;
  logic [31:0] dm_rdata;
  logic [31:0] rf_rs;
  logic [31:0] rf_rt;
  rf_wr_t      rf_wr;
  dm_req_t     dm_req;

  // execute decode
  logic [5:0]  op;
  logic [31:0] imm;
  logic [31:0] pc4;
  logic [31:0] ea;
  logic        stop;
  logic [31:0] next;
  logic        rw;
  logic [4:0]  ri;
  logic [31:0] rv;
  logic        is_load;
  logic        is_store;

  // write-back leaves when the output register is free or being emptied
  assign wb_fire = wb_valid && (!result.valid || result.ready);

  // operands are read at the accepting edge, so the last write must land
  // no later than that edge
  assign instr.ready = !dm_busy && !ex_valid && (!wb_valid || wb_fire);
  assign accept      = instr.valid && instr.ready;

  mipsx_regfile u_regfile (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rs_idx  (instr.instruction_word[25:21]),
    .rt_idx  (instr.instruction_word[20:16]),
    .wr      (rf_wr),
    .rs_data (rf_rs),
    .rt_data (rf_rt)
  );

  mipsx_dmem #(
    .DATA_MEM_BYTES (DATA_MEM_BYTES)
  ) u_dmem (
    .clk   (clk),
    .rst   (rst),
    .req   (dm_req),
    .busy  (dm_busy),
    .rdata (dm_rdata)
  );

  // execute: alu, branch and jump targets, memory request
  always_comb begin
    op       = ex_instr[31:26];
    imm      = sign_ext16(ex_instr[15:0]);
    pc4      = pc + 32'd4;
    ea       = rf_rs + imm;
    stop     = halt_seen || ex_instr == HALT_WORD;
    next     = pc4;
    rw       = 1'b0;
    ri       = ex_instr[20:16];
    rv       = '0;
    is_load  = 1'b0;
    is_store = 1'b0;
    if (stop) begin
      next = pc;
    end else begin
      case (op)
        OP_RTYPE: begin
          ri = ex_instr[15:11];
          rw = 1'b1;
          case (ex_instr[2:0])
            FN_ADDU: rv = rf_rs + rf_rt;
            FN_SUBU: rv = rf_rs - rf_rt;
            FN_AND:  rv = rf_rs & rf_rt;
            FN_OR:   rv = rf_rs | rf_rt;
            FN_NOR:  rv = ~(rf_rs | rf_rt);
            default: rw = 1'b0;
          endcase
        end
        OP_ADDIU: begin
          rw = 1'b1;
          rv = ea;
        end
        OP_BEQ: begin
          if (rf_rs == rf_rt) begin
            next = pc4 + {imm[29:0], 2'b00};
          end
        end
        OP_LW: begin
          rw      = 1'b1;
          is_load = 1'b1;
        end
        OP_SW: begin
          is_store = 1'b1;
        end
        OP_J: begin
          next = (pc4 & JUMP_REGION_MASK) | {4'b0000, ex_instr[25:0], 2'b00};
        end
        default: ;
      endcase
    end
    // writes to r0 are dropped
    if (ri == 5'd0) begin
      rw      = 1'b0;
      is_load = 1'b0;
    end
  end

  always_comb begin
    dm_req.wr    = ex_valid && is_store;
    dm_req.rd    = ex_valid && is_load;
    dm_req.addr  = ea;
    dm_req.wdata = rf_rt;
  end

  always_comb begin
    rf_wr.en   = wb_fire && wb_rw;
    rf_wr.idx  = wb_ri;
    rf_wr.data = wb_load ? dm_rdata : wb_rv;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      ex_valid     <= 1'b0;
      wb_valid     <= 1'b0;
      result.valid <= 1'b0;
      pc           <= '0;
      halt_seen    <= 1'b0;
    end else begin
      ex_valid <= accept;
      // the write-back stage is always free when execute holds a request
      if (ex_valid) begin
        wb_valid <= 1'b1;
      end else if (wb_fire) begin
        wb_valid <= 1'b0;
      end
      if (wb_fire) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
      if (ex_valid) begin
        pc <= next;
        if (stop) begin
          halt_seen <= 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      ex_instr <= instr.instruction_word;
    end
    if (ex_valid) begin
      wb_next_pc <= next;
      wb_halted  <= stop;
      wb_rw      <= rw;
      wb_ri      <= rw ? ri : 5'd0;
      wb_rv      <= rv;
      wb_load    <= is_load;
      wb_mw      <= is_store;
      wb_ma      <= is_store ? 16'(ea & BYTE_MASK) : 16'd0;
      wb_mv      <= is_store ? rf_rt : 32'd0;
    end
    if (wb_fire) begin
      result.next_pc           <= wb_next_pc;
      result.halted            <= wb_halted;
      result.reg_write_done    <= wb_rw;
      result.reg_write_index   <= wb_ri;
      result.reg_write_value   <= wb_rw ? rf_wr.data : 32'd0;
      result.mem_write_done    <= wb_mw;
      result.mem_write_address <= wb_ma;
      result.mem_write_value   <= wb_mv;
    end
  end

`ifndef SYNTHESIS
  // a request in execute always moves on to write-back
  a_ex_to_wb: assert property (@(posedge clk) disable iff (rst)
    ex_valid |=> wb_valid)
    else $error("request lost between execute and write-back");

  // once halted the core stays halted
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    halt_seen |=> halt_seen)
    else $error("halt flag cleared");

  // r0 is never reported as written
  a_no_r0_write: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.reg_write_done |-> result.reg_write_index != 5'd0)
    else $error("write to r0 reported");

  // no request is taken while the data memory sweep runs
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    dm_busy |-> !instr.ready)
    else $error("request accepted during memory clear");
`endif

endmodule
